@@ rtl/core/chw_pkg.sv @@
// shared types, constants and the tanh lookup table of the harmonic waveshaper
`default_nettype none

package chw_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int ARG_W    = 41;
  localparam int U_W      = 38;
  localparam int FRAC_W   = 16;

  // tanh table intervals over [-4,4], TANH_N + 1 points with both ends
  localparam int TANH_N = 256;
  localparam int IDX_W  = $clog2(TANH_N);
  localparam int TAB_AW = $clog2(TANH_N + 1);
  localparam int PROD_W = U_W + IDX_W;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_GAIN,
    REG_SECOND_WEIGHT,
    REG_THIRD_WEIGHT,
    REG_MIX_GAIN
  } cfg_reg_t;

  localparam logic        [GAIN_W-1:0] DRIVE_GAIN_RST    = 16'd4096;
  localparam logic signed [GAIN_W-1:0] SECOND_WEIGHT_RST = 16'sd8192;
  localparam logic signed [GAIN_W-1:0] THIRD_WEIGHT_RST  = 16'sd4096;
  localparam logic signed [GAIN_W-1:0] MIX_GAIN_RST      = 16'sd16384;

  localparam logic signed [ARG_W-1:0]    ARG_FOUR = ARG_W'(64'sd1 <<< 37);
  localparam logic signed [ARG_W-1:0]    ARG_NEG_FOUR = -ARG_FOUR;
  localparam logic signed [SAMPLE_W-1:0] NEG_ONE = 24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] POS_MAX = 24'sh7FFFFF;

  localparam longint Q30_ONE   = 64'sd1 <<< 30;
  localparam longint E_INV_Q30 = 64'sd395007542;

  typedef logic signed [SAMPLE_W-1:0] tanh_tab_t [0:TANH_N];

  // shift-and-subtract quotient of non-negative operands, only used while building the table
  function automatic longint div_u(longint num, longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      q   = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // tanh(-4 + 8k/N) in Q1.23, e^-v by a truncated Taylor series and repeated 1/e
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t tab;
    longint    d;
    longint    mag;
    longint    v;
    longint    ip;
    longint    fr;
    longint    term;
    longint    sum;
    longint    r;
    longint    t;
    longint    j;
    bit        neg;
    for (int k = 0; k <= TANH_N; k++) begin
      d    = 16 * longint'(k) - 8 * longint'(TANH_N);
      neg  = d < 0;
      mag  = neg ? -d : d;
      v    = (mag <<< 30) / TANH_N;
      ip   = v >>> 30;
      fr   = v & (Q30_ONE - 1);
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (j = 1; j <= 12; j++) begin
        term = div_u((term * fr) >>> 30, j);
        sum  = (j % 2 == 1) ? sum - term : sum + term;
      end
      r = (sum < 0) ? 64'sd0 : ((sum > Q30_ONE) ? Q30_ONE : sum);
      for (j = 0; j < ip; j++) begin
        r = (r * E_INV_Q30) >>> 30;
      end
      t = div_u((Q30_ONE - r) <<< 30, Q30_ONE + r);
      t = (t + 64) >>> 7;
      tab[k] = SAMPLE_W'(neg ? -t : t);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

`default_nettype wire

@@ rtl/core/chw_if.sv @@
// valid/ready stream channels for input samples and harmonic results
`default_nettype none

interface chw_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_in;
  logic               block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink (input valid, input sample_in, input block_end, output ready);
endinterface

interface chw_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic               block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/chebyshev_harmonic_waveshaper_top.sv @@
// Chebyshev harmonic waveshaper: drive, tanh soft clip, T2/T3 mix, output tanh.
//
// sample_ch takes one signed Q1.23 sample and a block_end flag per beat;
// result_ch gives one Q1.23 harmonic sample per input beat, in order, with
// block_end passed through. Both are valid/ready channels.
// cfg_we/cfg_index/cfg_data write drive_gain, second_weight, third_weight
// and mix_gain (indexes 0 to 3); write them only while no beat is in flight.
// The path from input beat to result valid holds one drive multiply
// stage, four stages per tanh unit and six stages of harmonic arithmetic.
// Throughput is one beat per cycle while result_ch is ready; every stage
// holds its own valid bit. When result_ch stalls, the last register holds
// its beat and empty stages behind it still fill, so sample_ch drops ready
// only once every stage holds a beat. Nothing is lost or repeated across a
// stall. Synchronous reset empties the pipeline and loads the register
// defaults (drive 1.0, second 0.5, third 0.25, mix 1.0). The tanh table is
// constant logic, so the block is ready in the cycle after reset.
`default_nettype none

module chebyshev_harmonic_waveshaper_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  chw_in_if.sink                                  sample_ch,
  chw_out_if.source                               result_ch,
  input  wire logic                               cfg_we,
  input  wire logic [chw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [chw_pkg::GAIN_W-1:0]         cfg_data
);
  import chw_pkg::*;

  logic        [GAIN_W-1:0] drive_gain;
  logic signed [GAIN_W-1:0] second_weight;
  logic signed [GAIN_W-1:0] third_weight;
  logic signed [GAIN_W-1:0] mix_gain;

  logic                       drv_v, drv_rdy, drv_tag;
  logic signed [ARG_W-1:0]    drv_w;
  logic                       t1_in_ready, t1_v, t1_tag;
  logic signed [SAMPLE_W-1:0] t1_c;
  logic                       h_in_ready, h_v, h_tag;
  logic signed [ARG_W-1:0]    h_arg;
  logic                       t2_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain    <= DRIVE_GAIN_RST;
      second_weight <= SECOND_WEIGHT_RST;
      third_weight  <= THIRD_WEIGHT_RST;
      mix_gain      <= MIX_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DRIVE_GAIN:    drive_gain    <= cfg_data;
        REG_SECOND_WEIGHT: second_weight <= cfg_data;
        REG_THIRD_WEIGHT:  third_weight  <= cfg_data;
        REG_MIX_GAIN:      mix_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  // drive stage: x * drive_gain, exact in Q.35
  assign drv_rdy         = ~drv_v | t1_in_ready;
  assign sample_ch.ready = drv_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      drv_v <= 1'b0;
    end else if (drv_rdy) begin
      drv_v <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (drv_rdy) begin
      drv_w   <= sample_ch.sample_in * $signed({1'b0, drive_gain});
      drv_tag <= sample_ch.block_end;
    end
  end

  chw_tanh u_clip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (drv_v),
    .in_ready  (t1_in_ready),
    .arg       (drv_w),
    .in_tag    (drv_tag),
    .out_valid (t1_v),
    .out_ready (h_in_ready),
    .res       (t1_c),
    .out_tag   (t1_tag)
  );

  chw_harm u_harm (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (t1_v),
    .in_ready      (h_in_ready),
    .c             (t1_c),
    .in_tag        (t1_tag),
    .second_weight (second_weight),
    .third_weight  (third_weight),
    .mix_gain      (mix_gain),
    .out_valid     (h_v),
    .out_ready     (t2_in_ready),
    .arg           (h_arg),
    .out_tag       (h_tag)
  );

  chw_tanh u_shape (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_v),
    .in_ready  (t2_in_ready),
    .arg       (h_arg),
    .in_tag    (h_tag),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .res       (result_ch.sample_out),
    .out_tag   (result_ch.block_end_out)
  );

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !sample_ch.ready |-> result_ch.valid && !result_ch.ready)
    else $error("input blocked while the pipeline still has room");

endmodule

`default_nettype wire

@@ rtl/core/chw_tanh.sv @@
// four-stage tanh unit: table lookup with linear interpolation, saturating outside [-4,4)
`default_nettype none

module chw_tanh (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [chw_pkg::ARG_W-1:0]    arg,
  input  wire logic                                in_tag,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [chw_pkg::SAMPLE_W-1:0]      res,
  output logic                                     out_tag
);
  import chw_pkg::*;

  logic                       rdy1, rdy2, rdy3, rdy4;
  logic                       s1_v, s2_v, s3_v;
  logic                       s1_lo, s1_hi, s2_lo, s2_hi, s3_lo, s3_hi;
  logic                       s1_tag, s2_tag, s3_tag;
  logic [IDX_W-1:0]           s1_i;
  logic [FRAC_W-1:0]          s1_f, s2_f;
  logic signed [SAMPLE_W-1:0] s2_base, s3_base;
  logic signed [SAMPLE_W:0]   s2_d;
  logic signed [SAMPLE_W+FRAC_W+1:0] s3_prod;

  logic signed [ARG_W-1:0]    shifted;
  logic [PROD_W-1:0]          pos;
  logic signed [SAMPLE_W-1:0] tab_lo, tab_hi;
  logic signed [SAMPLE_W+1:0] interp;

  assign rdy4     = ~out_valid | out_ready;
  assign rdy3     = ~s3_v | rdy4;
  assign rdy2     = ~s2_v | rdy3;
  assign rdy1     = ~s1_v | rdy2;
  assign in_ready = rdy1;

  // position on the table grid: (w + 4) * N / 8, integer part is the index
  assign shifted = arg + ARG_FOUR;
  assign pos     = PROD_W'(shifted[U_W-1:0]) * PROD_W'(TANH_N);
  assign tab_lo  = TANH_TAB[TAB_AW'(s1_i)];
  assign tab_hi  = TANH_TAB[TAB_AW'(s1_i) + TAB_AW'(1)];
  assign interp  = {{2{s3_base[SAMPLE_W-1]}}, s3_base} + s3_prod[SAMPLE_W+FRAC_W+1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) s1_v <= in_valid;
      if (rdy2) s2_v <= s1_v;
      if (rdy3) s3_v <= s2_v;
      if (rdy4) out_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_lo  <= arg < ARG_NEG_FOUR;
      s1_hi  <= arg >= ARG_FOUR;
      s1_i   <= pos[U_W +: IDX_W];
      s1_f   <= pos[U_W-1 -: FRAC_W];
      s1_tag <= in_tag;
    end
    if (rdy2) begin
      s2_lo   <= s1_lo;
      s2_hi   <= s1_hi;
      s2_base <= tab_lo;
      s2_d    <= {tab_hi[SAMPLE_W-1], tab_hi} - {tab_lo[SAMPLE_W-1], tab_lo};
      s2_f    <= s1_f;
      s2_tag  <= s1_tag;
    end
    if (rdy3) begin
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
      s3_base <= s2_base;
      s3_prod <= s2_d * $signed({1'b0, s2_f});
      s3_tag  <= s2_tag;
    end
    if (rdy4) begin
      if (s3_lo) begin
        res <= NEG_ONE;
      end else if (s3_hi) begin
        res <= POS_MAX;
      end else begin
        res <= interp[SAMPLE_W-1:0];
      end
      out_tag <= s3_tag;
    end
  end

  a_range_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> !(s1_lo && s1_hi))
    else $error("tanh argument flagged both below and above range");

  a_low_saturates: assert property (@(posedge clk) disable iff (rst)
    s3_v && rdy4 && s3_lo |=> out_valid && res == NEG_ONE)
    else $error("tanh below range did not give minus one");

  a_high_saturates: assert property (@(posedge clk) disable iff (rst)
    s3_v && rdy4 && s3_hi |=> out_valid && res == POS_MAX)
    else $error("tanh above range did not give full scale");

endmodule

`default_nettype wire

@@ rtl/core/chw_harm.sv @@
// six-stage datapath: chebyshev terms T2 and T3, weighting, sum and mix gain
`default_nettype none

module chw_harm (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [chw_pkg::SAMPLE_W-1:0] c,
  input  wire logic                              in_tag,
  input  wire logic signed [chw_pkg::GAIN_W-1:0] second_weight,
  input  wire logic signed [chw_pkg::GAIN_W-1:0] third_weight,
  input  wire logic signed [chw_pkg::GAIN_W-1:0] mix_gain,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [chw_pkg::ARG_W-1:0]       arg,
  output logic                                   out_tag
);
  import chw_pkg::*;

  localparam int NS = 6;
  localparam logic signed [47:0] C2_MAX = 48'sd1 <<< 46;

  logic [NS-1:0] v;
  logic [NS-1:0] tag;
  logic [NS:0]   rdy;

  logic signed [SAMPLE_W-1:0] c_0, c_1;
  logic signed [47:0] c2_0;
  logic signed [47:0] t2_1, c3_1, t3_2;
  logic signed [63:0] p2_2, p2_3, p3_3;
  logic signed [38:0] a_4;
  logic signed [54:0] m_5;

  logic signed [48:0] c3_full;
  logic signed [50:0] t3_full;
  logic signed [63:0] acc;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // c^3 from floor(c^2 / 2^23), T3 = 4c^3 - 3c
  assign c3_full = $signed({1'b0, c2_0[46:23]}) * c_0;
  assign t3_full = (51'(c3_1) <<< 2) - ((51'(c_1) * 51'sd3) <<< 23);
  assign acc     = p2_3 + p3_3;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tag[0] <= in_tag;
      c_0    <= c;
      c2_0   <= c * c;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) tag[k] <= tag[k-1];
    end
    if (rdy[1]) begin
      c_1  <= c_0;
      t2_1 <= (c2_0 <<< 1) - C2_MAX;
      c3_1 <= c3_full[47:0];
    end
    if (rdy[2]) begin
      t3_2 <= t3_full[47:0];
      p2_2 <= t2_1 * second_weight;
    end
    if (rdy[3]) begin
      p2_3 <= p2_2;
      p3_3 <= t3_2 * third_weight;
    end
    if (rdy[4]) begin
      a_4 <= acc[63:25];
    end
    if (rdy[5]) begin
      m_5 <= a_4 * mix_gain;
    end
  end

  assign out_valid = v[NS-1];
  assign out_tag   = tag[NS-1];
  assign arg       = m_5[54:14];

  a_square_range: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> c2_0 >= 0 && c2_0 <= C2_MAX)
    else $error("square of soft-clipped sample out of range");

  a_t2_range: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> t2_1 >= -C2_MAX && t2_1 <= C2_MAX)
    else $error("second chebyshev term out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] && !out_ready |=> v[NS-1] && $stable(m_5) && $stable(tag[NS-1]))
    else $error("stalled harmonic sum changed");

endmodule

`default_nettype wire
